// ----- design/srsc_pkg.sv -----
// shared types and constants for the syn/rst scan counter
package srsc_pkg;

    // fixed field widths
    localparam int ADDR_W      = 32;
    localparam int PROTO_W     = 8;
    localparam int THR_W       = 16;
    localparam int RPT_CNT_W   = 16;

    // configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    // word index bit of the only register
    localparam logic REG_SCAN_THRESHOLD = 1'b0;

    // protocol and reset constants
    localparam logic [PROTO_W-1:0]   PROTO_TCP  = 8'd6;
    localparam logic [THR_W-1:0]     THR_RESET  = 16'd100;
    localparam logic [RPT_CNT_W-1:0] RPT_CNT_MAX = 16'hFFFF;

    // controller to datapath commands
    typedef struct packed {
        logic accept;     // load a new request
        logic key_dst;    // restart lookup with the destination address
        logic rd;         // read table slot at the scan index
        logic idx_inc;    // advance scan index
        logic wr_new;     // allocate next free slot with count one
        logic wr_upd;     // bump count of the slot at the scan index
        logic set_ovf;    // mark the table as overflowed
        logic load_pend;  // hold current slot as pending report entry
        logic push_mid;   // send pending entry, not last
        logic push_end;   // send final result of the report
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic in_valid;   // request offered
        logic in_rpt;     // offered request is a report
        logic in_src_ev;  // offered packet bumps its source
        logic in_rst_ev;  // offered packet bumps its destination
        logic at_end;     // scan index reached fill count
        logic full;       // every slot taken
        logic hit;        // slot read back matches the key
        logic qual;       // slot read back exceeds the threshold
        logic pend_vld;   // a report entry is pending
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

// ----- design/srsc_in_if.sv -----
// request channel: one parsed packet header or a report request
interface srsc_in_if;
    import srsc_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [PROTO_W-1:0] ip_protocol;
    logic [ADDR_W-1:0]  source_address;
    logic [ADDR_W-1:0]  dest_address;
    logic               flag_syn;
    logic               flag_ack;
    logic               flag_rst;

    modport source (
        output valid, action, ip_protocol, source_address, dest_address,
               flag_syn, flag_ack, flag_rst,
        input  ready
    );
    modport sink (
        input  valid, action, ip_protocol, source_address, dest_address,
               flag_syn, flag_ack, flag_rst,
        output ready
    );
endinterface

// ----- design/srsc_out_if.sv -----
// result channel: one report entry
interface srsc_out_if;
    import srsc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    reported_address;
    logic [RPT_CNT_W-1:0] reported_count;
    logic                 entry_valid;
    logic                 table_overflowed;
    logic                 last_of_report;

    modport source (
        output valid, reported_address, reported_count, entry_valid,
               table_overflowed, last_of_report,
        input  ready
    );
    modport sink (
        input  valid, reported_address, reported_count, entry_valid,
               table_overflowed, last_of_report,
        output ready
    );
endinterface

// ----- design/srsc_ram.sv -----
// generic single-port-write, registered-read ram
module srsc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/srsc_ctrl.sv -----
// controller: sequences lookups, allocation and report scans
module srsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  srsc_pkg::t_sts i_sts,
    output srsc_pkg::t_cmd o_cmd,
    output logic           o_in_ready
);
    import srsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CMP,
        S_RPT_RD,
        S_RPT_CMP,
        S_RPT_END
    } t_state;

    t_state r_state, n_state;
    logic   r_dst_pend, n_dst_pend;
    t_cmd   cmd;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_dst_pend = r_dst_pend;
        cmd        = '0;
        case (r_state)
            S_IDLE: begin
                cmd.accept = i_sts.in_valid;
                if (i_sts.in_valid) begin
                    if (i_sts.in_rpt) begin
                        n_state = S_RPT_RD;
                    end else if (i_sts.in_src_ev) begin
                        n_state    = S_LK_RD;
                        n_dst_pend = i_sts.in_rst_ev;
                    end else if (i_sts.in_rst_ev) begin
                        n_state    = S_LK_RD;
                        n_dst_pend = 1'b0;
                    end
                end
            end
            S_LK_RD: begin
                if (i_sts.at_end) begin
                    // address not in table
                    cmd.wr_new  = !i_sts.full;
                    cmd.set_ovf = i_sts.full;
                    if (r_dst_pend) begin
                        cmd.key_dst = 1'b1;
                        n_dst_pend  = 1'b0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_LK_CMP;
                end
            end
            S_LK_CMP: begin
                if (i_sts.hit) begin
                    cmd.wr_upd = 1'b1;
                    if (r_dst_pend) begin
                        cmd.key_dst = 1'b1;
                        n_dst_pend  = 1'b0;
                        n_state     = S_LK_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_LK_RD;
                end
            end
            S_RPT_RD: begin
                if (i_sts.at_end) begin
                    n_state = S_RPT_END;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_RPT_CMP;
                end
            end
            S_RPT_CMP: begin
                if (!i_sts.qual) begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_RPT_RD;
                end else if (!i_sts.pend_vld || i_sts.out_free) begin
                    // older pending entry leaves, this one waits for a successor
                    cmd.push_mid  = i_sts.pend_vld;
                    cmd.load_pend = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    n_state       = S_RPT_RD;
                end
            end
            S_RPT_END: begin
                if (i_sts.out_free) begin
                    cmd.push_end = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dst_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_dst_pend <= n_dst_pend;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);
endmodule

// ----- design/srsc_dpath.sv -----
// datapath: address/count table, scan index, pending entry and output register
module srsc_dpath #(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  srsc_pkg::t_cmd                     i_cmd,
    output srsc_pkg::t_sts                     o_sts,
    input  logic [srsc_pkg::THR_W-1:0]         i_thr,
    // request fields
    input  logic                               i_in_valid,
    input  logic                               i_action,
    input  logic [srsc_pkg::PROTO_W-1:0]       i_ip_protocol,
    input  logic [srsc_pkg::ADDR_W-1:0]        i_source_address,
    input  logic [srsc_pkg::ADDR_W-1:0]        i_dest_address,
    input  logic                               i_flag_syn,
    input  logic                               i_flag_ack,
    input  logic                               i_flag_rst,
    // result register
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [srsc_pkg::ADDR_W-1:0]        o_reported_address,
    output logic [srsc_pkg::RPT_CNT_W-1:0]     o_reported_count,
    output logic                               o_entry_valid,
    output logic                               o_table_overflowed,
    output logic                               o_last_of_report
);
    import srsc_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W  = ADDR_W + COUNT_WIDTH;
    localparam int CMP_W  = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    // control registers
    logic [FILL_W-1:0] r_idx;
    logic [FILL_W-1:0] r_filled;
    logic              r_ovf;
    logic              r_pend_vld;
    logic              r_out_vld;
    // payload registers
    logic [ADDR_W-1:0]    r_key;
    logic [ADDR_W-1:0]    r_dst;
    logic [ADDR_W-1:0]    r_pend_addr;
    logic [RPT_CNT_W-1:0] r_pend_cnt;
    logic [ADDR_W-1:0]    r_out_addr;
    logic [RPT_CNT_W-1:0] r_out_cnt;
    logic                 r_out_ent;
    logic                 r_out_ovf;
    logic                 r_out_last;

    logic [ENT_W-1:0]       rd_ent;
    logic [ADDR_W-1:0]      rd_addr;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic [CMP_W-1:0]       rd_cnt_ext;
    logic [COUNT_WIDTH-1:0] bump_cnt;
    logic [RPT_CNT_W-1:0]   sat_cnt;
    logic                   we;
    logic [IDX_W-1:0]       waddr;
    logic [ENT_W-1:0]       wdata;
    logic                   tcp;
    logic                   out_free;

    // table storage: address in the upper bits, count in the lower
    srsc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_ent)
    );

    // slot read back and count arithmetic
    assign rd_addr    = rd_ent[ENT_W-1:COUNT_WIDTH];
    assign rd_cnt     = rd_ent[COUNT_WIDTH-1:0];
    assign rd_cnt_ext = CMP_W'(rd_cnt);
    assign bump_cnt   = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
    assign sat_cnt    = (rd_cnt_ext > CMP_W'(RPT_CNT_MAX)) ? RPT_CNT_MAX
                                                          : rd_cnt_ext[RPT_CNT_W-1:0];

    // table write: new slot at the fill count, update at the scan index
    assign we    = i_cmd.wr_new | i_cmd.wr_upd;
    assign waddr = i_cmd.wr_new ? r_filled[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign wdata = i_cmd.wr_new ? {r_key, COUNT_WIDTH'(1)} : {r_key, bump_cnt};

    // status
    assign tcp      = (i_ip_protocol == PROTO_TCP);
    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        o_sts           = '0;
        o_sts.in_valid  = i_in_valid;
        o_sts.in_rpt    = i_action;
        o_sts.in_src_ev = tcp && i_flag_syn && !i_flag_ack;
        o_sts.in_rst_ev = tcp && i_flag_rst;
        o_sts.at_end    = (r_idx == r_filled);
        o_sts.full      = (r_filled == FILL_W'(TABLE_DEPTH));
        o_sts.hit       = (rd_addr == r_key);
        o_sts.qual      = (rd_cnt_ext > CMP_W'(i_thr));
        o_sts.pend_vld  = r_pend_vld;
        o_sts.out_free  = out_free;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_filled   <= '0;
            r_ovf      <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.accept || i_cmd.key_dst) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.wr_new) begin
                r_filled <= r_filled + 1'b1;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.accept) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.load_pend) begin
                r_pend_vld <= 1'b1;
            end
            if (i_cmd.push_mid || i_cmd.push_end) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // lookup key and pending entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key <= o_sts.in_src_ev ? i_source_address : i_dest_address;
            r_dst <= i_dest_address;
        end else if (i_cmd.key_dst) begin
            r_key <= r_dst;
        end
        if (i_cmd.load_pend) begin
            r_pend_addr <= rd_addr;
            r_pend_cnt  <= sat_cnt;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_mid || i_cmd.push_end) begin
            r_out_ovf  <= r_ovf;
            r_out_last <= i_cmd.push_end;
            if (i_cmd.push_end && !r_pend_vld) begin
                // empty report
                r_out_addr <= '0;
                r_out_cnt  <= '0;
                r_out_ent  <= 1'b0;
            end else begin
                r_out_addr <= r_pend_addr;
                r_out_cnt  <= r_pend_cnt;
                r_out_ent  <= 1'b1;
            end
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_reported_address = r_out_addr;
    assign o_reported_count   = r_out_cnt;
    assign o_entry_valid      = r_out_ent;
    assign o_table_overflowed = r_out_ovf;
    assign o_last_of_report   = r_out_last;
endmodule

// ----- design/syn_rst_scan_counter.sv -----
// Accounting request: accepted from idle, then per counted event the table is searched
//   slot by slot, and a new slot is taken, or overflow marked, if the address is new (at most 2 events).
// Report request: scans every filled slot and can stall on the output; one result per
//   qualifying slot, held in the output register. Rate is set by the one-read
//   port table scan in the datapath, one request in flight at a time.
// Reset (synchronous, active low) empties the table, clears overflow, sets threshold to 100.
module syn_rst_scan_counter #(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    srsc_in_if.sink                           i_req,
    srsc_out_if.source                        o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srsc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [srsc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [srsc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import srsc_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic [THR_W-1:0] r_thr;
    logic             reg_sel;

    // configuration register
    assign reg_sel = (paddr[2] == REG_SCAN_THRESHOLD);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? APB_DATA_W'(r_thr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    // controller
    srsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (i_req.ready)
    );

    // datapath
    srsc_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_thr              (r_thr),
        .i_in_valid         (i_req.valid),
        .i_action           (i_req.action),
        .i_ip_protocol      (i_req.ip_protocol),
        .i_source_address   (i_req.source_address),
        .i_dest_address     (i_req.dest_address),
        .i_flag_syn         (i_req.flag_syn),
        .i_flag_ack         (i_req.flag_ack),
        .i_flag_rst         (i_req.flag_rst),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_reported_address (o_rsp.reported_address),
        .o_reported_count   (o_rsp.reported_count),
        .o_entry_valid      (o_rsp.entry_valid),
        .o_table_overflowed (o_rsp.table_overflowed),
        .o_last_of_report   (o_rsp.last_of_report)
    );

`ifndef NO_ASSERTIONS
    // never allocate a slot in a full table
    a_no_alloc_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr_new |-> !sts.full)
        else $error("slot allocated while table full");

    // at most one table action per cycle
    a_one_table_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr_new, cmd.wr_upd, cmd.set_ovf}))
        else $error("conflicting table actions");

    // a pending entry only leaves into a free output register
    a_push_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push_mid |-> (sts.pend_vld && sts.out_free))
        else $error("pending entry pushed without room");

    // the final result of a report frees the request side
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push_end |=> i_req.ready)
        else $error("not ready after final result of report");
`endif
endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the syn/rst scan counter: directed, stress and random requests
`timescale 1ns / 100ps

module testbench;
    import srsc_pkg::*;

    // block sizing, kept at the block's defaults
    localparam int          DEPTH        = 64;
    localparam int          CNT_W        = 16;
    localparam int unsigned CNT_MAX      = (1 << CNT_W) - 1;

    // request kinds
    localparam logic        ACT_COUNT    = 1'b0;
    localparam logic        ACT_REPORT   = 1'b1;

    // threshold register byte address
    localparam logic [APB_ADDR_W-1:0] THR_PADDR = {REG_SCAN_THRESHOLD, 2'b00};

    // run shape
    localparam int          POOL_N       = 20;
    localparam int          PHASES       = 5;
    localparam int          PHASE_ITEMS  = 80;
    localparam int          HAMMER_ITEMS = 64;
    localparam logic [ADDR_W-1:0] HOT_ADDR = 32'h0A00_0001;
    // idle time in settle, enough for an accounting request on a full table to finish
    localparam int          DRAIN_CYCLES = 300;
    localparam int          QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic               action;
        logic [PROTO_W-1:0] proto;
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dst;
        logic               syn;
        logic               ack;
        logic               rst;
    } pkt_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    address;
        logic [RPT_CNT_W-1:0] count;
        logic                 flagged;
        logic                 overflow;
        logic                 last;
    } scan_report_t;

    typedef struct {
        pkt_req_t     req;
        bit           typed;
        scan_report_t want;
    } dir_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    srsc_in_if  pkt_if ();
    srsc_out_if rpt_if ();

    syn_rst_scan_counter #(
        .TABLE_DEPTH (DEPTH),
        .COUNT_WIDTH (CNT_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (pkt_if),
        .o_rsp   (rpt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block's table and threshold
    logic [ADDR_W-1:0] slot_addr  [DEPTH];
    int unsigned       slot_count [DEPTH];
    bit                slot_used  [DEPTH];
    int unsigned       slots_taken;
    bit                table_full_seen;
    logic [THR_W-1:0]  thr_now;

    scan_report_t      due_reports [$];
    dir_row_t          dir_rows [$];
    logic [ADDR_W-1:0] addr_pool [POOL_N];

    bit                gaps_on;
    int                fail_count;
    int                pkts_sent;
    int                reports_sent;
    int                results_seen;
    int                flagged_seen;
    int                thr_writes;
    int                quiet_cycles;
    int                ready_left;
    bit                ready_stall;

    // one event on an address: find its slot, allocate, or mark overflow
    function automatic void tally_address(logic [ADDR_W-1:0] a);
        for (int i = 0; i < DEPTH; i++) begin
            if (slot_used[i] && slot_addr[i] == a) begin
                if (slot_count[i] < CNT_MAX)
                    slot_count[i]++;
                return;
            end
        end
        if (slots_taken < DEPTH) begin
            slot_addr[slots_taken]  = a;
            slot_count[slots_taken] = 1;
            slot_used[slots_taken]  = 1'b1;
            slots_taken++;
        end else begin
            table_full_seen = 1'b1;
        end
    endfunction

    // apply one accepted request and queue the results it should produce
    function automatic void predict_request(pkt_req_t r);
        scan_report_t found [$];
        scan_report_t e;
        if (r.action == ACT_COUNT) begin
            if (r.proto == PROTO_TCP) begin
                if (r.syn && !r.ack)
                    tally_address(r.src);
                if (r.rst)
                    tally_address(r.dst);
            end
        end else begin
            for (int i = 0; i < DEPTH; i++) begin
                if (slot_used[i] && slot_count[i] > thr_now) begin
                    e.address  = slot_addr[i];
                    e.count    = (slot_count[i] > RPT_CNT_MAX) ? RPT_CNT_MAX
                                                               : RPT_CNT_W'(slot_count[i]);
                    e.flagged  = 1'b1;
                    e.overflow = table_full_seen;
                    e.last     = 1'b0;
                    found.push_back(e);
                end
            end
            if (found.size() == 0) begin
                e          = '0;
                e.overflow = table_full_seen;
                e.last     = 1'b1;
                found.push_back(e);
            end else begin
                found[found.size()-1].last = 1'b1;
            end
            foreach (found[k])
                due_reports.push_back(found[k]);
        end
    endfunction

    // address from the hot pool most of the time, else a fresh one
    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 9) < 7)
            return addr_pool[$urandom_range(0, POOL_N - 1)];
        return $urandom;
    endfunction

    // mostly well-formed tcp headers, some noise protocols and reports
    function automatic pkt_req_t random_request();
        pkt_req_t    r;
        int unsigned pick;
        r.action = ACT_COUNT;
        r.proto  = PROTO_TCP;
        r.src    = pick_address();
        r.dst    = pick_address();
        r.syn    = ($urandom_range(0, 9) < 7);
        r.ack    = ($urandom_range(0, 9) < 3);
        r.rst    = 1'($urandom_range(0, 1));
        pick     = $urandom_range(0, 99);
        if (pick < 8) begin
            r.action = ACT_REPORT;
            r.proto  = PROTO_W'($urandom_range(0, 255));
        end else if (pick < 20) begin
            r.proto = PROTO_W'($urandom_range(0, 255));
            if (r.proto == PROTO_TCP)
                r.proto = 8'd17;
        end else if (pick < 25) begin
            r.dst = r.src;
        end
        return r;
    endfunction

    function automatic void add_row(logic act, logic [PROTO_W-1:0] proto,
                                    logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                                    logic syn, logic ack, logic rst,
                                    bit typed = 1'b0, scan_report_t want = '0);
        dir_row_t row;
        row.req   = '{act, proto, src, dst, syn, ack, rst};
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // offer one request, with an optional gap first, and predict on acceptance
    task automatic send_request(pkt_req_t r, bit typed = 1'b0, scan_report_t want = '0);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            pkt_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pkt_if.action         <= r.action;
        pkt_if.ip_protocol    <= r.proto;
        pkt_if.source_address <= r.src;
        pkt_if.dest_address   <= r.dst;
        pkt_if.flag_syn       <= r.syn;
        pkt_if.flag_ack       <= r.ack;
        pkt_if.flag_rst       <= r.rst;
        pkt_if.valid          <= 1'b1;
        @(posedge i_clk);
        while (!pkt_if.ready)
            @(posedge i_clk);
        if (typed)
            due_reports.push_back(want);
        else
            predict_request(r);
        if (r.action == ACT_REPORT)
            reports_sent++;
        else
            pkts_sent++;
    endtask

    // drop valid, wait for every expected result, then let a counting request finish
    task automatic settle();
        @(negedge i_clk);
        pkt_if.valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // threshold register access: a write updates the shadow, a read checks it
    task automatic thr_access(bit wr, logic [THR_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= THR_PADDR;
        pwdata  <= APB_DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (wr) begin
            thr_now = val;
            thr_writes++;
        end else if (prdata !== APB_DATA_W'(val)) begin
            $display("%0t: threshold readback expected %h actual %h", $time,
                     APB_DATA_W'(val), prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_threshold(logic [THR_W-1:0] val);
        thr_access(1'b1, val);
        thr_access(1'b0, val);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        scan_report_t want;
        if (i_rst_n && rpt_if.valid && rpt_if.ready) begin
            results_seen++;
            if (rpt_if.entry_valid === 1'b1)
                flagged_seen++;
            if (due_reports.size() == 0) begin
                $display("%0t: unexpected result expected none actual addr %h count %h",
                         $time, rpt_if.reported_address, rpt_if.reported_count);
                fail_count++;
            end else begin
                want = due_reports.pop_front();
                check_field("reported_address", want.address, rpt_if.reported_address);
                check_field("reported_count", 32'(want.count), 32'(rpt_if.reported_count));
                check_field("entry_valid", 32'(want.flagged), 32'(rpt_if.entry_valid));
                check_field("table_overflowed", 32'(want.overflow),
                            32'(rpt_if.table_overflowed));
                check_field("last_of_report", 32'(want.last), 32'(rpt_if.last_of_report));
            end
        end
    end

    // result ready: random stall bursts between ready stretches while gaps are on, else held high
    always @(negedge i_clk) begin
        if (!gaps_on) begin
            rpt_if.ready <= 1'b1;
        end else begin
            if (ready_left == 0) begin
                ready_stall = ($urandom_range(0, 3) == 0);
                ready_left  = ready_stall ? $urandom_range(1, 16) : $urandom_range(1, 40);
            end
            ready_left--;
            rpt_if.ready <= !ready_stall;
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (pkt_if.valid && pkt_if.ready) || (rpt_if.valid && rpt_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        scan_report_t     empty_rpt;
        pkt_req_t         hammer;
        logic [THR_W-1:0] phase_thr [PHASES];

        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        pkt_if.valid          = 1'b0;
        pkt_if.action         = ACT_COUNT;
        pkt_if.ip_protocol    = '0;
        pkt_if.source_address = '0;
        pkt_if.dest_address   = '0;
        pkt_if.flag_syn       = 1'b0;
        pkt_if.flag_ack       = 1'b0;
        pkt_if.flag_rst       = 1'b0;
        rpt_if.ready          = 1'b0;
        gaps_on               = 1'b0;
        fail_count            = 0;
        pkts_sent             = 0;
        reports_sent          = 0;
        results_seen          = 0;
        flagged_seen          = 0;
        thr_writes            = 0;
        quiet_cycles          = 0;
        ready_left            = 0;
        ready_stall           = 1'b0;
        slots_taken           = 0;
        table_full_seen       = 1'b0;
        thr_now               = THR_RESET;
        foreach (slot_used[i]) begin
            slot_used[i]  = 1'b0;
            slot_addr[i]  = '0;
            slot_count[i] = 0;
        end
        foreach (addr_pool[i])
            addr_pool[i] = $urandom;

        // reset
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // threshold comes out of reset at its default, then drop to zero
        thr_access(1'b0, THR_RESET);
        write_threshold('0);

        // directed requests
        empty_rpt      = '0;
        empty_rpt.last = 1'b1;
        // report on an empty table
        add_row(ACT_REPORT, 8'h00, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b1, empty_rpt);
        // first syn takes slot zero
        add_row(ACT_COUNT, PROTO_TCP, HOT_ADDR, 32'hC0A8_0001, 1'b1, 1'b0, 1'b0);
        // non-tcp protocols are ignored
        add_row(ACT_COUNT, 8'd17, 32'hC0A8_0002, 32'hC0A8_0003, 1'b1, 1'b0, 1'b1);
        add_row(ACT_COUNT, 8'h00, 32'hC0A8_0002, 32'hC0A8_0003, 1'b1, 1'b0, 1'b1);
        add_row(ACT_COUNT, 8'hFF, 32'hC0A8_0002, 32'hC0A8_0003, 1'b1, 1'b0, 1'b1);
        add_row(ACT_COUNT, 8'd7, 32'hC0A8_0002, 32'hC0A8_0003, 1'b1, 1'b0, 1'b1);
        // syn-ack counts nothing
        add_row(ACT_COUNT, PROTO_TCP, 32'hC0A8_0004, 32'hC0A8_0005, 1'b1, 1'b1, 1'b0);
        // rst alone bumps the destination
        add_row(ACT_COUNT, PROTO_TCP, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
        // same address on both sides bumps twice
        add_row(ACT_COUNT, PROTO_TCP, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b1);
        // syn-ack with rst: destination only
        add_row(ACT_COUNT, PROTO_TCP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 1'b1);
        // no flags
        add_row(ACT_COUNT, PROTO_TCP, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0, 1'b0, 1'b0);
        add_row(ACT_COUNT, PROTO_TCP, 32'hFFFF_FFFF, HOT_ADDR, 1'b1, 1'b0, 1'b1);
        // ack alone
        add_row(ACT_COUNT, PROTO_TCP, 32'h5555_AAAA, 32'hAAAA_5555, 1'b0, 1'b1, 1'b0);
        // reports ignore the packet fields
        add_row(ACT_REPORT, PROTO_TCP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        add_row(ACT_REPORT, 8'hFF, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0);

        gaps_on = 1'b1;
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        settle();

        // push the hot address counter well above the low thresholds
        gaps_on = 1'b0;
        hammer  = '{ACT_COUNT, PROTO_TCP, HOT_ADDR, HOT_ADDR, 1'b1, 1'b0, 1'b1};
        repeat (HAMMER_ITEMS)
            send_request(hammer);
        send_request('{ACT_REPORT, 8'h00, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0});
        settle();

        // threshold at its top and just below it
        gaps_on = 1'b1;
        write_threshold(16'hFFFF);
        send_request('{ACT_REPORT, 8'h5A, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0});
        settle();
        write_threshold(16'hFFFE);
        send_request('{ACT_REPORT, 8'hA5, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0});
        settle();

        // random phases, the last one with no idling and every entry reported
        phase_thr[0] = 16'd1;
        phase_thr[1] = 16'd2;
        phase_thr[2] = THR_W'($urandom_range(4, 6));
        phase_thr[3] = 16'd3;
        phase_thr[4] = '0;
        for (int p = 0; p < PHASES; p++) begin
            write_threshold(phase_thr[p]);
            gaps_on = (p < PHASES - 1);
            repeat (PHASE_ITEMS - 1)
                send_request(random_request());
            send_request('{ACT_REPORT, 8'h00, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0});
            settle();
        end

        $display("covered %0d packet requests and %0d reports, %0d results (%0d flagged)",
                 pkts_sent, reports_sent, results_seen, flagged_seen);
        $display("%0d threshold writes, %0d of %0d slots filled, overflow %0d",
                 thr_writes, slots_taken, DEPTH, table_full_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
